// File: rtl/accel_step_counter_activity_top_assert.svh
// Assertion macros for the checker file
`ifndef ACCEL_STEP_COUNTER_ACTIVITY_TOP_ASSERT_SVH
`define ACCEL_STEP_COUNTER_ACTIVITY_TOP_ASSERT_SVH

// Implication checked at the same edge
`define ACSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked at the following edge
`define ACSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/acsc_pkg.sv
package acsc_pkg;

  // Input transaction
  typedef struct packed {
    logic               req_type;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0]        time_ms;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [31:0] step_total;
    logic [3:0]  new_steps;
    logic [1:0]  activity;
  } out_t;

  // Request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // Register indexes
  localparam logic [2:0] REG_MIN_THRESHOLD   = 3'd0;
  localparam logic [2:0] REG_INIT_THRESHOLD  = 3'd1;
  localparam logic [2:0] REG_MIN_STEP_GAP_MS = 3'd2;
  localparam logic [2:0] REG_VALID_WINDOW_MS = 3'd3;
  localparam logic [2:0] REG_IDLE_MS         = 3'd4;
  localparam logic [2:0] REG_WALK_SPM_MIN    = 3'd5;
  localparam logic [2:0] REG_RUN_SPM_MIN     = 3'd6;

  // Activity codes
  localparam logic [1:0] ACT_REST = 2'd0;
  localparam logic [1:0] ACT_WALK = 2'd1;
  localparam logic [1:0] ACT_RUN  = 2'd2;

  localparam int unsigned MIN_HISTORY   = 3;
  localparam int unsigned MS_PER_MINUTE = 60000;

endpackage

// File: rtl/accel_step_counter_activity_top.sv
// Step counter with activity classification. Each sample transaction runs
// through one shared 17 x N multiply-accumulate unit and a bit-serial square
// root under a small sequencer: an accept state, the sum of squares, the
// square root (one result bit per cycle), gravity and threshold averaging,
// step detection, one history write per recorded step (0 to CONFIRM_STEPS),
// classification and the hand-over of the result to the output register.
// When at least 3 intervals are kept and the wearer is not idle, an interval
// sum over the kept intervals, read from the history memory, and the rate
// compare come before the hand-over. A clear request goes from the accept
// state straight to the hand-over. The input is stalled while a transaction
// is in work; a finished result waits in an output register while the next
// transaction is taken, and a result that finds that register still held
// waits in the last state. Configuration writes are always accepted and must
// only be issued while the block is idle.
module accel_step_counter_activity_top #(
  parameter int unsigned HISTORY_DEPTH      = 8,
  parameter int unsigned CONFIRM_STEPS      = 4,
  parameter int unsigned GRAVITY_WEIGHT_Q16 = 62259,
  parameter int unsigned THRESH_WEIGHT_Q16  = 58982
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  acsc_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output acsc_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(HISTORY_DEPTH);
  localparam int unsigned HC_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned PC_W  = (CONFIRM_STEPS > 1) ? $clog2(CONFIRM_STEPS + 1) : 1;
  localparam int unsigned SUM_W = 32 + HC_W;
  localparam int unsigned MB_W  = SUM_W;
  localparam int unsigned ACC_W = 17 + MB_W;
  localparam int unsigned CNT_W = (HC_W > 5) ? HC_W : 5;

  localparam logic [16:0] GW  = 17'(GRAVITY_WEIGHT_Q16);
  localparam logic [16:0] GWC = 17'(65536 - GRAVITY_WEIGHT_Q16);
  localparam logic [16:0] TW  = 17'(THRESH_WEIGHT_Q16);
  localparam logic [16:0] TWC = 17'(65536 - THRESH_WEIGHT_Q16);
  localparam logic [ACC_W-1:0] ROUND = ACC_W'(32768);

  // Sequencer codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQ   = 4'd1;
  localparam logic [3:0] ST_SQRT = 4'd2;
  localparam logic [3:0] ST_SEED = 4'd3;
  localparam logic [3:0] ST_G0   = 4'd4;
  localparam logic [3:0] ST_G1   = 4'd5;
  localparam logic [3:0] ST_T0   = 4'd6;
  localparam logic [3:0] ST_T1   = 4'd7;
  localparam logic [3:0] ST_DET  = 4'd8;
  localparam logic [3:0] ST_REC  = 4'd9;
  localparam logic [3:0] ST_CLS  = 4'd10;
  localparam logic [3:0] ST_SUM  = 4'd11;
  localparam logic [3:0] ST_M0   = 4'd12;
  localparam logic [3:0] ST_M1   = 4'd13;
  localparam logic [3:0] ST_M2   = 4'd14;
  localparam logic [3:0] ST_DONE = 4'd15;

  // Configuration registers
  logic [15:0] min_thr_q, init_thr_q, gap_min_q, window_q, idle_q;
  logic [9:0]  walk_q, run_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_thr_q  <= 16'd200;
      init_thr_q <= 16'd400;
      gap_min_q  <= 16'd250;
      window_q   <= 16'd2000;
      idle_q     <= 16'd3000;
      walk_q     <= 10'd60;
      run_q      <= 10'd140;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        acsc_pkg::REG_MIN_THRESHOLD:   min_thr_q  <= cfg_data_i;
        acsc_pkg::REG_INIT_THRESHOLD:  init_thr_q <= cfg_data_i;
        acsc_pkg::REG_MIN_STEP_GAP_MS: gap_min_q  <= cfg_data_i;
        acsc_pkg::REG_VALID_WINDOW_MS: window_q   <= cfg_data_i;
        acsc_pkg::REG_IDLE_MS:         idle_q     <= cfg_data_i;
        acsc_pkg::REG_WALK_SPM_MIN:    walk_q     <= cfg_data_i[9:0];
        acsc_pkg::REG_RUN_SPM_MIN:     run_q      <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Control state
  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             seeded_q, seeded_d, armed_q, armed_d, runc_q, runc_d;
  logic [31:0]      last_q, last_d, steps_q, steps_d;
  logic [PC_W-1:0]  pc_q, pc_d;
  logic [IDX_W-1:0] hidx_q, hidx_d;
  logic [HC_W-1:0]  hcnt_q, hcnt_d;
  logic [1:0]       act_q, act_d;
  logic [3:0]       rec_q, rec_d, news_q, news_d;
  logic             out_valid_q, out_valid_d;
  // Payload
  logic signed [15:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [31:0]      now_q, now_d, first_q, first_d, gap_q, gap_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [47:0]      rad_q, rad_d;
  logic [25:0]      rem_q, rem_d;
  logic [23:0]      root_q, root_d, grav_q, grav_d, thr_q, thr_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  acsc_pkg::out_t   out_q, out_d;
  logic [31:0]      hist_mem [HISTORY_DEPTH];
  logic [31:0]      hist_rd_q;
  logic             hist_we, hist_re;

  // Shared multiply unit
  logic [16:0]      mul_a;
  logic [MB_W-1:0]  mul_b;
  logic [ACC_W-1:0] mul_p, mac;
  logic signed [15:0] axis;
  logic [15:0]      axis_abs;

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    axis = x_q;
      2'd1:    axis = y_q;
      default: axis = z_q;
    endcase
    axis_abs = axis[15] ? (~axis + 16'd1) : axis;
  end

  // Detector arithmetic
  logic signed [24:0] diff;
  logic [23:0]        absacc, floor_q, eff;
  logic signed [25:0] diff_x, diff_x2, eff_s;
  logic [26:0]        rem_sh, trial;

  assign diff    = $signed({1'b0, root_q}) - $signed({1'b0, grav_q});
  assign absacc  = diff[24] ? 24'(-diff) : diff[23:0];
  assign floor_q = {min_thr_q, 8'd0};
  assign eff     = (thr_q < floor_q) ? floor_q : thr_q;
  assign diff_x  = 26'(diff);
  assign diff_x2 = {diff, 1'b0};
  assign eff_s   = $signed({2'b00, eff});
  assign rem_sh  = {rem_q[24:0], rad_q[47:46]};
  assign trial   = {1'b0, root_q, 2'b01};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQ: begin
        mul_a = {1'b0, axis_abs};
        mul_b = MB_W'(axis_abs);
      end
      ST_G0: begin mul_a = GW;  mul_b = MB_W'(grav_q); end
      ST_G1: begin mul_a = GWC; mul_b = MB_W'(root_q); end
      ST_T0: begin mul_a = TW;  mul_b = MB_W'(thr_q); end
      ST_T1: begin mul_a = TWC; mul_b = MB_W'(absacc); end
      ST_M0: begin
        mul_a = 17'(acsc_pkg::MS_PER_MINUTE);
        mul_b = MB_W'(hcnt_q);
      end
      ST_M1: begin mul_a = {7'd0, run_q};  mul_b = sum_q; end
      ST_M2: begin mul_a = {7'd0, walk_q}; mul_b = sum_q; end
      default: ;
    endcase
  end

  assign mul_p = ACC_W'(mul_a) * ACC_W'(mul_b);
  assign mac   = acc_q + mul_p;

  // Sequencer
  always_comb begin
    logic [31:0]     gap, span;
    state_d = state_q;   cnt_d = cnt_q;     seeded_d = seeded_q;
    armed_d = armed_q;   runc_d = runc_q;   last_d = last_q;
    steps_d = steps_q;   pc_d = pc_q;       hidx_d = hidx_q;
    hcnt_d = hcnt_q;     act_d = act_q;     rec_d = rec_q;
    news_d = news_q;     x_d = x_q;         y_d = y_q;
    z_d = z_q;           now_d = now_q;     first_d = first_q;
    gap_d = gap_q;       acc_d = acc_q;     rad_d = rad_q;
    rem_d = rem_q;       root_d = root_q;   grav_d = grav_q;
    thr_d = thr_q;       sum_d = sum_q;     out_d = out_q;
    hist_we = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    gap  = now_q - last_q;
    // a single pending step spans nothing
    span = (pc_q == '0 || CONFIRM_STEPS == 1) ? '0 : now_q - first_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          news_d = '0;
          if (in_data_i.req_type == acsc_pkg::REQ_CLEAR) begin
            steps_d = '0; last_d = '0; hidx_d = '0; hcnt_d = '0;
            armed_d = 1'b0; pc_d = '0; runc_d = 1'b0;
            state_d = ST_DONE;
          end else begin
            x_d = in_data_i.accel_x;
            y_d = in_data_i.accel_y;
            z_d = in_data_i.accel_z;
            now_d = in_data_i.time_ms;
            acc_d = '0;
            cnt_d = '0;
            state_d = ST_SQ;
          end
        end
      end
      // sum of squares, one axis a cycle; the last one loads the radicand
      ST_SQ: begin
        acc_d = mac;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(2)) begin
          rad_d   = {mac[31:0], 16'd0};
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = '0;
          state_d = ST_SQRT;
        end
      end
      // square root iteration, one result bit a cycle
      ST_SQRT: begin
        rad_d = {rad_q[45:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_d  = 26'(rem_sh - trial);
          root_d = {root_q[22:0], 1'b1};
        end else begin
          rem_d  = rem_sh[25:0];
          root_d = {root_q[22:0], 1'b0};
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(23)) state_d = ST_SEED;
      end
      ST_SEED: begin
        if (!seeded_q) begin
          grav_d   = root_q;
          thr_d    = {init_thr_q, 8'd0};
          seeded_d = 1'b1;
        end
        state_d = ST_G0;
      end
      ST_G0: begin acc_d = ROUND + mul_p; state_d = ST_G1; end
      ST_G1: begin grav_d = mac[39:16]; state_d = ST_T0; end
      ST_T0: begin acc_d = ROUND + mul_p; state_d = ST_T1; end
      ST_T1: begin thr_d = mac[39:16]; state_d = ST_DET; end
      // arm, release and run confirmation
      ST_DET: begin
        state_d = ST_CLS;
        gap_d = gap;
        if (!armed_q) begin
          if (diff_x > eff_s) armed_d = 1'b1;
        end else if (diff_x2 < eff_s) begin
          armed_d = 1'b0;
          if (gap > {16'd0, gap_min_q}) begin
            last_d = now_q;
            if (runc_q) begin
              if (gap > {16'd0, window_q}) begin
                runc_d = 1'b0; first_d = now_q; pc_d = PC_W'(1);
              end else begin
                rec_d = 4'd1; state_d = ST_REC;
              end
            end else begin
              if (pc_q == '0) first_d = now_q;
              if (pc_q >= PC_W'(CONFIRM_STEPS - 1)) begin
                if (span <= {16'd0, window_q}) begin
                  rec_d = 4'(CONFIRM_STEPS); runc_d = 1'b1; state_d = ST_REC;
                end
                pc_d = '0;
              end else begin
                pc_d = pc_q + PC_W'(1);
              end
            end
          end
        end
      end
      // one history write per counted step
      ST_REC: begin
        hist_we = 1'b1;
        hidx_d  = (hidx_q == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : hidx_q + IDX_W'(1);
        if (hcnt_q < HC_W'(HISTORY_DEPTH)) hcnt_d = hcnt_q + HC_W'(1);
        steps_d = steps_q + 32'd1;
        news_d  = news_q + 4'd1;
        rec_d   = rec_q - 4'd1;
        if (rec_q == 4'd1) state_d = ST_CLS;
      end
      ST_CLS: begin
        if ((now_q - last_q) > {16'd0, idle_q}) begin
          act_d = acsc_pkg::ACT_REST;
          state_d = ST_DONE;
        end else if (hcnt_q >= HC_W'(acsc_pkg::MIN_HISTORY)) begin
          sum_d = '0; cnt_d = '0; state_d = ST_SUM;
        end else begin
          state_d = ST_DONE;
        end
      end
      // interval sum; the read data is registered and arrives in the cycle after its address
      ST_SUM: begin
        if (cnt_q != '0) sum_d = sum_q + SUM_W'(hist_rd_q);
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(hcnt_q)) state_d = ST_M0;
      end
      ST_M0: begin acc_d = mul_p; state_d = ST_M1; end
      ST_M1: begin
        if (acc_q > mul_p) begin
          act_d = acsc_pkg::ACT_RUN; state_d = ST_DONE;
        end else begin
          state_d = ST_M2;
        end
      end
      ST_M2: begin
        act_d = (acc_q > mul_p) ? acsc_pkg::ACT_WALK : acsc_pkg::ACT_REST;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.step_total = steps_q;
          out_d.new_steps  = news_q;
          out_d.activity   = act_q;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;   cnt_q <= '0;      seeded_q <= 1'b0;
      armed_q <= 1'b0;      runc_q <= 1'b0;   last_q <= '0;
      steps_q <= '0;        pc_q <= '0;       hidx_q <= '0;
      hcnt_q <= '0;         act_q <= acsc_pkg::ACT_REST;
      rec_q <= '0;          news_q <= '0;     out_valid_q <= 1'b0;
      grav_q <= '0;         thr_q <= 24'd400 << 8;
    end else begin
      state_q <= state_d;   cnt_q <= cnt_d;   seeded_q <= seeded_d;
      armed_q <= armed_d;   runc_q <= runc_d; last_q <= last_d;
      steps_q <= steps_d;   pc_q <= pc_d;     hidx_q <= hidx_d;
      hcnt_q <= hcnt_d;     act_q <= act_d;
      rec_q <= rec_d;       news_q <= news_d; out_valid_q <= out_valid_d;
      grav_q <= grav_d;     thr_q <= thr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;   y_q <= y_d;   z_q <= z_d;
    now_q <= now_d; first_q <= first_d; gap_q <= gap_d;
    acc_q <= acc_d; rad_q <= rad_d; rem_q <= rem_d; root_q <= root_d;
    sum_q <= sum_d; out_q <= out_d;
  end

  // Interval history ring, written per step and read back for the sum
  assign hist_re = (state_q == ST_SUM) && (cnt_q < CNT_W'(hcnt_q));

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hidx_q] <= gap_q;
    end
    if (hist_re) begin
      hist_rd_q <= hist_mem[cnt_q[IDX_W-1:0]];
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/acsc_checker.sv
`include "accel_step_counter_activity_top_assert.svh"

module acsc_checker #(
  parameter int unsigned CONFIRM_STEPS = 4
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input acsc_pkg::out_t out_data_o
);

  // a held result keeps its value
  `ACSC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "result changed while stalled")

  // block is busy right after taking a transaction
  `ACSC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input taken twice in a row")

  // no more steps than one confirmed run per transaction
  `ACSC_ASSERT_NOW(a_new_steps_bound, out_valid_o, out_data_o.new_steps <= 4'(CONFIRM_STEPS), "too many new steps")

  // activity code stays in its range
  `ACSC_ASSERT_NOW(a_activity_range, out_valid_o, out_data_o.activity != 2'd3, "bad activity code")

endmodule

bind accel_step_counter_activity_top acsc_checker #(
  .CONFIRM_STEPS(CONFIRM_STEPS)
) u_acsc_checker (.*);

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned HIST_DEPTH   = 8;
  localparam int unsigned CONFIRM_N    = 4;
  localparam int unsigned GRAV_W       = 62259;
  localparam int unsigned THR_W        = 58982;
  localparam int unsigned NUM_RANDOM   = 1900;
  localparam longint      CYCLE_LIMIT  = 1500000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  acsc_pkg::in_t  in_data_i;
  acsc_pkg::out_t out_data_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  accel_step_counter_activity_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Register shadow
  logic [15:0] thr_floor_r, thr_init_r, gap_min_r, window_r, idle_r;
  logic [9:0]  walk_spm_r, run_spm_r;

  // Detector shadow state
  logic [23:0] grav_q, thr_q;
  bit          seeded, armed, confirmed;
  logic [31:0] last_step_ms;
  logic [31:0] pend_ms [CONFIRM_N];
  int unsigned pend_cnt;
  logic [31:0] intervals [HIST_DEPTH];
  int unsigned hist_idx, hist_cnt;
  logic [31:0] step_cnt;
  logic [1:0]  act_lvl;

  acsc_pkg::in_t  sample_q[$];
  acsc_pkg::out_t expected_q[$];
  int   errors = 0;
  int   results_seen = 0;
  longint cycle_cnt = 0;
  bit   idle_free = 0;
  bit   hold_recv = 0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [23:0] ema(input int unsigned w, input logic [63:0] old_v,
                                      input logic [63:0] smp);
    logic [63:0] s;
    s = 64'(w) * old_v + 64'(65536 - w) * smp + 64'd32768;
    return 24'(s >> 16);
  endfunction

  function automatic void log_step(input logic [31:0] ival);
    intervals[hist_idx % HIST_DEPTH] = ival;
    hist_idx = (hist_idx + 1) % HIST_DEPTH;
    if (hist_cnt < HIST_DEPTH) hist_cnt++;
    step_cnt++;
  endfunction

  function automatic void reset_shadow();
    thr_floor_r = 200; thr_init_r = 400; gap_min_r = 250; window_r = 2000;
    idle_r = 3000; walk_spm_r = 60; run_spm_r = 140;
    grav_q = 0; thr_q = 24'(400) << 8; seeded = 0; armed = 0; confirmed = 0;
    last_step_ms = 0; pend_cnt = 0; hist_idx = 0; hist_cnt = 0; step_cnt = 0;
    act_lvl = acsc_pkg::ACT_REST;
    for (int i = 0; i < CONFIRM_N; i++) pend_ms[i] = 0;
    for (int i = 0; i < HIST_DEPTH; i++) intervals[i] = 0;
  endfunction

  // Predict the result of one sample or clear transaction
  function automatic acsc_pkg::out_t step_predict(input acsc_pkg::in_t it);
    acsc_pkg::out_t r;
    logic [3:0] added;
    longint x, y, z, acc, absacc;
    logic [63:0] sq, sum, lhs;
    logic [31:0] mag, now_ms, gap, span, eff, floor_q;
    added = 0;
    if (it.req_type == acsc_pkg::REQ_CLEAR) begin
      step_cnt = 0; last_step_ms = 0; hist_idx = 0; hist_cnt = 0;
      armed = 0; pend_cnt = 0; confirmed = 0;
    end else begin
      x = it.accel_x; y = it.accel_y; z = it.accel_z;
      now_ms = it.time_ms;
      sq = 64'(x * x) + 64'(y * y) + 64'(z * z);
      mag = 32'(int_sqrt(sq << 16));
      if (!seeded) begin
        grav_q = 24'(mag);
        thr_q = 24'(thr_init_r) << 8;
        seeded = 1;
      end
      grav_q = ema(GRAV_W, 64'(grav_q), 64'(mag));
      acc = longint'(mag) - longint'(grav_q);
      absacc = acc < 0 ? -acc : acc;
      thr_q = ema(THR_W, 64'(thr_q), 64'(absacc));
      floor_q = 32'(thr_floor_r) << 8;
      eff = 32'(thr_q) < floor_q ? floor_q : 32'(thr_q);
      if (!armed) begin
        if (acc > longint'(eff)) armed = 1;
      end else if (2 * acc < longint'(eff)) begin
        gap = now_ms - last_step_ms;
        armed = 0;
        if (gap > gap_min_r) begin
          if (confirmed) begin
            if (gap > window_r) begin
              confirmed = 0;
              pend_ms[0] = now_ms;
              pend_cnt = 1;
            end else begin
              log_step(gap);
              added = 1;
            end
          end else begin
            if (pend_cnt < CONFIRM_N) begin
              pend_ms[pend_cnt] = now_ms;
              pend_cnt++;
            end
            if (pend_cnt >= CONFIRM_N) begin
              span = pend_ms[(pend_cnt - 1) % CONFIRM_N] - pend_ms[0];
              if (span <= window_r) begin
                for (int i = 0; i < pend_cnt; i++) log_step(gap);
                added = 4'(pend_cnt);
                confirmed = 1;
              end
              pend_cnt = 0;
            end
          end
          last_step_ms = now_ms;
        end
      end
      if (32'(now_ms - last_step_ms) > idle_r) begin
        act_lvl = acsc_pkg::ACT_REST;
      end else if (hist_cnt >= acsc_pkg::MIN_HISTORY) begin
        sum = 0;
        for (int i = 0; i < hist_cnt && i < HIST_DEPTH; i++) sum += intervals[i];
        lhs = 64'(acsc_pkg::MS_PER_MINUTE) * hist_cnt;
        if (lhs > 64'(run_spm_r) * sum) act_lvl = acsc_pkg::ACT_RUN;
        else if (lhs > 64'(walk_spm_r) * sum) act_lvl = acsc_pkg::ACT_WALK;
        else act_lvl = acsc_pkg::ACT_REST;
      end
    end
    r.step_total = step_cnt;
    r.new_steps = added;
    r.activity = act_lvl;
    return r;
  endfunction

  // Clock and cycle watchdog
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t timeout, %0d results pending", $time, expected_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sender: bursts of idle between transactions
  int send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
      in_data_i  <= '0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        void'(sample_q.pop_front());
        expected_q.push_back(step_predict(in_data_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 0;
        end else if (sample_q.size() > 0) begin
          in_data_i  <= sample_q[0];
          in_valid_i <= 1;
          if (!idle_free && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 17);
        end else begin
          in_valid_i <= 0;
        end
      end
    end
  end

  // Receiver: random stall bursts plus an occasional long hold-off
  int stall_left = 0;
  int hold_left  = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 0;
      stall_left  <= 0;
      hold_left   <= 0;
    end else begin
      if (hold_recv && hold_left == 0) hold_left <= 400;
      if (hold_left > 0) begin
        out_stall_i <= 1;
        hold_left <= hold_left - 1;
      end else if (stall_left > 0) begin
        out_stall_i <= 1;
        stall_left <= stall_left - 1;
      end else if (!idle_free && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1;
        stall_left <= $urandom_range(0, 16);
      end else begin
        out_stall_i <= 0;
      end
    end
  end

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    acsc_pkg::out_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result %p", $time, out_data_o);
      end else begin
        exp_r = expected_q.pop_front();
        if (out_data_o.step_total !== exp_r.step_total) begin
          errors++;
          $display("%0t step_total exp %0d got %0d", $time, exp_r.step_total,
                   out_data_o.step_total);
        end
        if (out_data_o.new_steps !== exp_r.new_steps) begin
          errors++;
          $display("%0t new_steps exp %0d got %0d", $time, exp_r.new_steps,
                   out_data_o.new_steps);
        end
        if (out_data_o.activity !== exp_r.activity) begin
          errors++;
          $display("%0t activity exp %0d got %0d", $time, exp_r.activity,
                   out_data_o.activity);
        end
      end
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      acsc_pkg::REG_MIN_THRESHOLD:   thr_floor_r = val;
      acsc_pkg::REG_INIT_THRESHOLD:  thr_init_r  = val;
      acsc_pkg::REG_MIN_STEP_GAP_MS: gap_min_r   = val;
      acsc_pkg::REG_VALID_WINDOW_MS: window_r    = val;
      acsc_pkg::REG_IDLE_MS:         idle_r      = val;
      acsc_pkg::REG_WALK_SPM_MIN:    walk_spm_r  = val[9:0];
      acsc_pkg::REG_RUN_SPM_MIN:     run_spm_r   = val[9:0];
      default: ;
    endcase
    cfg_valid_i <= 0;
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || expected_q.size() != 0 || in_valid_i) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic push_sample(input logic signed [15:0] x, y, z, input logic [31:0] t);
    acsc_pkg::in_t it;
    it.req_type = acsc_pkg::REQ_SAMPLE;
    it.accel_x = x; it.accel_y = y; it.accel_z = z; it.time_ms = t;
    sample_q.push_back(it);
  endtask

  task automatic push_clear();
    acsc_pkg::in_t it;
    it = acsc_pkg::in_t'({$urandom, $urandom, $urandom});
    it.req_type = acsc_pkg::REQ_CLEAR;
    sample_q.push_back(it);
  endtask

  // Walking-like stream: per step a quiet sample, a spike and a rest sample, period plus random jitter
  task automatic push_walk(input int n_steps, input logic [31:0] t0,
                           input int unsigned period_ms, input int jitter);
    logic [31:0] t;
    logic signed [15:0] spike;
    t = t0;
    for (int s = 0; s < n_steps; s++) begin
      spike = 16'($urandom_range(3000, 32767));
      if ($urandom_range(0, 1)) spike = -spike;
      push_sample(16'($signed($urandom_range(0, 200)) - 100),
                  16'($signed($urandom_range(0, 200)) - 100), 16'sd1000, t);
      push_sample(spike, 16'($urandom), 16'sd1000, t + period_ms / 3);
      push_sample(16'sd0, 16'sd0, 16'sd1000, t + 2 * period_ms / 3);
      t = t + period_ms + $urandom_range(0, jitter);
    end
  endtask

  task automatic push_noise(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) push_clear();
      else push_sample(16'($urandom), 16'($urandom), 16'($urandom), $urandom);
    end
  endtask

  logic [31:0] t_base;
  int planned;

  initial begin
    rst_ni = 0;
    cfg_valid_i = 0; cfg_index_i = '0; cfg_data_i = '0;
    reset_shadow();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    repeat (2) @(posedge clk_i);

    // Directed: field extremes, clear, first-sample seeding, wrap of time
    push_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF);
    push_sample(-16'sh8000, -16'sh8000, -16'sh8000, 32'h0);
    push_sample(16'sd0, 16'sd0, 16'sd0, 32'h0000_0010);
    push_clear();
    push_sample(-16'sh8000, 16'sh7FFF, 16'sd0, 32'h5555_AAAA);
    push_sample(16'sd1, -16'sd1, 16'sd0, 32'hAAAA_5555);
    push_walk(6, 32'hFFFF_FF00, 500, 20);
    push_clear();
    drain();

    // Register extremes, defaults and random settings, then walk/run cadences and noise under each setting
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          cfg_write(acsc_pkg::REG_MIN_THRESHOLD, 16'd0);
          cfg_write(acsc_pkg::REG_INIT_THRESHOLD, 16'hFFFF);
          cfg_write(acsc_pkg::REG_MIN_STEP_GAP_MS, 16'd0);
          cfg_write(acsc_pkg::REG_VALID_WINDOW_MS, 16'hFFFF);
          cfg_write(acsc_pkg::REG_IDLE_MS, 16'hFFFF);
          cfg_write(acsc_pkg::REG_WALK_SPM_MIN, 16'd0);
          cfg_write(acsc_pkg::REG_RUN_SPM_MIN, 16'h3FF);
        end
        1: begin
          cfg_write(acsc_pkg::REG_MIN_THRESHOLD, 16'hFFFF);
          cfg_write(acsc_pkg::REG_INIT_THRESHOLD, 16'd0);
          cfg_write(acsc_pkg::REG_MIN_STEP_GAP_MS, 16'hFFFF);
          cfg_write(acsc_pkg::REG_VALID_WINDOW_MS, 16'd0);
          cfg_write(acsc_pkg::REG_IDLE_MS, 16'd0);
          cfg_write(acsc_pkg::REG_WALK_SPM_MIN, 16'hFFFF);
          cfg_write(acsc_pkg::REG_RUN_SPM_MIN, 16'd0);
        end
        2: begin
          cfg_write(acsc_pkg::REG_MIN_THRESHOLD, 16'd200);
          cfg_write(acsc_pkg::REG_INIT_THRESHOLD, 16'd400);
          cfg_write(acsc_pkg::REG_MIN_STEP_GAP_MS, 16'd250);
          cfg_write(acsc_pkg::REG_VALID_WINDOW_MS, 16'd2000);
          cfg_write(acsc_pkg::REG_IDLE_MS, 16'd3000);
          cfg_write(acsc_pkg::REG_WALK_SPM_MIN, 16'd60);
          cfg_write(acsc_pkg::REG_RUN_SPM_MIN, 16'd140);
        end
        default: begin
          for (int r = 0; r <= acsc_pkg::REG_RUN_SPM_MIN; r++) begin
            case (3'(r))
              acsc_pkg::REG_MIN_THRESHOLD:
                cfg_write(3'(r), 16'($urandom_range(0, 2000)));
              acsc_pkg::REG_INIT_THRESHOLD:
                cfg_write(3'(r), 16'($urandom_range(0, 4000)));
              acsc_pkg::REG_MIN_STEP_GAP_MS:
                cfg_write(3'(r), 16'($urandom_range(0, 600)));
              acsc_pkg::REG_VALID_WINDOW_MS:
                cfg_write(3'(r), 16'($urandom_range(500, 4000)));
              acsc_pkg::REG_IDLE_MS:
                cfg_write(3'(r), 16'($urandom_range(500, 8000)));
              acsc_pkg::REG_WALK_SPM_MIN:
                cfg_write(3'(r), 16'($urandom_range(0, 120)));
              default:
                cfg_write(3'(r), 16'($urandom_range(60, 1023)));
            endcase
          end
        end
      endcase
      planned = 0;
      t_base = $urandom;
      while (planned < NUM_RANDOM / 6) begin
        if ($urandom_range(0, 4) == 0) begin
          push_noise(8);
          planned += 8;
        end else begin
          int n;
          n = $urandom_range(2, 12);
          push_walk(n, t_base, $urandom_range(200, 1200), $urandom_range(0, 800));
          t_base = t_base + 32'(n * 1500 + $urandom_range(0, 5000));
          planned += 3 * n;
        end
      end
      // Long receiver hold-off once, while items keep coming
      if (phase == 3) begin
        hold_recv = 1;
        repeat (20) @(posedge clk_i);
        hold_recv = 0;
      end
      if (phase == 5) idle_free = 1;
      drain();
    end

    $display("Covered %0d checked results over six register settings,", results_seen);
    $display("including extremes, clears, cadence streams and random noise.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/acsc_pkg.sv
rtl/accel_step_counter_activity_top.sv
rtl/acsc_checker.sv
verif/testbench.sv
